// ----- rtl/core/osem_pkg.sv -----
// shared codes and controller/datapath interface types for the ordered store
package osem_pkg;

  // command codes of an input transaction
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_PEEK   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 5;

  // controller to datapath commands
  typedef struct packed {
    logic take;      // input transaction accepted
    logic scan;      // maximum search in progress
    logic shift;     // compaction in progress
    logic dec;       // compaction finished, drop one entry
    logic load_out;  // move pending result into output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic scan_last;   // last entry of the search is being compared
    logic shift_done;  // all later entries have moved down
  } sts_t;

endpackage

// ----- rtl/core/osem_ram.sv -----
// generic simple dual-port ram with registered read
module osem_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/osem_ctrl.sv -----
// controller state machine for the ordered store
module osem_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  osem_pkg::sts_t     sts_i,
  output osem_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   is_del_q, is_del_d;
  logic   out_vld_q, out_vld_d;

  // next state and commands
  always_comb begin
    state_d  = state_q;
    is_del_d = is_del_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          is_del_d   = (op_i == osem_pkg::OP_DELETE);
          unique case (op_i) inside
            osem_pkg::OP_DELETE, osem_pkg::OP_PEEK: begin
              state_d = sts_i.empty ? S_DONE : S_SCAN;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = is_del_q ? S_SHIFT : S_DONE;
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          cmd_o.dec = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd_o.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_del_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_del_q  <= is_del_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_vld_q;

endmodule

// ----- rtl/core/osem_dp.sv -----
// datapath: entry ram, fill count, maximum search, compaction and result registers
module osem_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [1:0]                          op_i,
  input  logic signed [osem_pkg::DataW-1:0]   data_value_i,
  input  osem_pkg::cmd_t                      cmd_i,
  output osem_pkg::sts_t                      sts_o,
  output logic signed [osem_pkg::DataW-1:0]   found_value_o,
  output logic [1:0]                          status_o,
  output logic [osem_pkg::CountW-1:0]         entry_count_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(CAPACITY);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  ptr_q, ptr_d;
  logic             rd_vld_q;
  logic [AddrW-1:0] rd_idx_q;
  logic signed [osem_pkg::DataW-1:0] best_q, best_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  logic signed [osem_pkg::DataW-1:0] res_found_q, res_found_d;
  logic [1:0]       res_status_q, res_status_d;
  logic signed [osem_pkg::DataW-1:0] found_q;
  logic [1:0]       status_q;
  logic [osem_pkg::CountW-1:0] count_q;

  logic                          rd_en;
  logic [osem_pkg::DataW-1:0]    rd_data;
  logic                          wr_en;
  logic [AddrW-1:0]              wr_addr;
  logic [osem_pkg::DataW-1:0]    wr_data;
  logic                          ins_ok;
  logic                          take_better;

  // status towards the controller
  assign sts_o.full       = (cnt_q == CntMax);
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.scan_last  = rd_vld_q && ({{(CntW-AddrW){1'b0}}, rd_idx_q} == cnt_q - 1'b1);
  assign sts_o.shift_done = !rd_vld_q && (ptr_q >= cnt_q);

  assign ins_ok = cmd_i.take && (op_i == osem_pkg::OP_INSERT) && !sts_o.full;

  // read issue during search and compaction
  assign rd_en = (cmd_i.scan || cmd_i.shift) && (ptr_q < cnt_q);

  // write port: append on insert, move down one place on compaction
  always_comb begin
    if (ins_ok) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[AddrW-1:0];
      wr_data = data_value_i;
    end else begin
      wr_en   = cmd_i.shift && rd_vld_q;
      wr_addr = rd_idx_q - 1'b1;
      wr_data = rd_data;
    end
  end

  osem_ram #(
    .WIDTH(osem_pkg::DataW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  // running maximum, earliest entry wins a tie
  assign take_better = (rd_idx_q == '0) || ($signed(rd_data) > best_q);

  always_comb begin
    best_d     = best_q;
    best_idx_d = best_idx_q;
    if (cmd_i.scan && rd_vld_q && take_better) begin
      best_d     = $signed(rd_data);
      best_idx_d = rd_idx_q;
    end
  end

  // read pointer and fill count
  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (cmd_i.take) begin
      ptr_d = '0;
    end else if (cmd_i.scan && sts_o.scan_last) begin
      ptr_d = {{(CntW-AddrW){1'b0}}, best_idx_d} + 1'b1;
    end else if (rd_en) begin
      ptr_d = ptr_q + 1'b1;
    end
    if (ins_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.dec) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // pending result
  always_comb begin
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    if (cmd_i.take) begin
      res_found_d = '0;
      case (op_i) inside
        osem_pkg::OP_INSERT: begin
          res_status_d = sts_o.full ? osem_pkg::ST_FULL : osem_pkg::ST_OK;
        end
        osem_pkg::OP_DELETE, osem_pkg::OP_PEEK: begin
          res_status_d = sts_o.empty ? osem_pkg::ST_EMPTY : osem_pkg::ST_OK;
        end
        default: res_status_d = osem_pkg::ST_OK;
      endcase
    end else if (cmd_i.scan && sts_o.scan_last) begin
      res_found_d = best_d;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ptr_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      ptr_q    <= ptr_d;
      rd_vld_q <= rd_en;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_idx_q <= ptr_q[AddrW-1:0];
    end
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    if (cmd_i.load_out) begin
      found_q  <= res_found_q;
      status_q <= res_status_q;
      count_q  <= osem_pkg::CountW'(cnt_q);
    end
  end

  assign found_value_o = found_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;

endmodule

// ----- rtl/core/ordered_store_extract_max_unit.sv -----
// top level of the ordered store with extract-max
// insert, op 3 and empty/full errors go from acceptance straight to the result; peek scans
// all N entries for the maximum; delete then compacts, moving each later entry down one place
// one transaction at a time; the next is taken once the result is loaded, while that result waits
// reset clears the fill count and handshake state; the ram is not cleared
module ordered_store_extract_max_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          op_i,
  input  logic signed [osem_pkg::DataW-1:0]   data_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [osem_pkg::DataW-1:0]   found_value_o,
  output logic [1:0]                          status_o,
  output logic [osem_pkg::CountW-1:0]         entry_count_o
);

  osem_pkg::cmd_t cmd;
  osem_pkg::sts_t sts;

  osem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  osem_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op_i),
    .data_value_i  (data_value_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .found_value_o (found_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

endmodule

// ----- tb/osem_result_checker.sv -----
`timescale 1ns / 100ps
// result checker for the ordered store: predicts every transaction and compares the results
module osem_result_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [1:0]                        op_i,
  input  logic signed [osem_pkg::DataW-1:0] data_value_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [osem_pkg::DataW-1:0] found_value_i,
  input  logic [1:0]                        status_i,
  input  logic [osem_pkg::CountW-1:0]       entry_count_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic signed [osem_pkg::DataW-1:0] found;
    logic [1:0]                        status;
    logic [osem_pkg::CountW-1:0]       count;
  } store_outcome_t;

  // shadow copy of the store
  logic signed [osem_pkg::DataW-1:0] shadow_entries [CAPACITY];
  int unsigned                       shadow_fill = 0;

  store_outcome_t store_outcome_q [$];
  store_outcome_t got_outcome;
  store_outcome_t want_outcome;
  int             fail_cnt = 0;

  assign fail_count_o = fail_cnt;

  // one command applied to the shadow store, giving the outcome it must produce
  task automatic apply_store_command(input logic [1:0] op,
                                     input logic signed [osem_pkg::DataW-1:0] val,
                                     output store_outcome_t res);
    int unsigned best;
    int unsigned k;
    res = '0;
    res.status = osem_pkg::ST_OK;
    case (op) inside
      osem_pkg::OP_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = osem_pkg::ST_FULL;
        end else begin
          shadow_entries[shadow_fill] = val;
          shadow_fill++;
        end
      end
      osem_pkg::OP_DELETE, osem_pkg::OP_PEEK: begin
        if (shadow_fill == 0) begin
          res.status = osem_pkg::ST_EMPTY;
        end else begin
          // earliest largest entry wins, search starts at the first entry
          best = 0;
          for (k = 1; k < shadow_fill; k++) begin
            if (shadow_entries[k] > shadow_entries[best]) best = k;
          end
          res.found = shadow_entries[best];
          if (op == osem_pkg::OP_DELETE) begin
            // later entries move down one place
            for (k = best; k + 1 < shadow_fill; k++) shadow_entries[k] = shadow_entries[k + 1];
            shadow_fill--;
          end
        end
      end
      default: ;
    endcase
    res.count = shadow_fill[osem_pkg::CountW-1:0];
  endtask

  task automatic report_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endtask

  // result side first, then the newly accepted command
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      shadow_fill = 0;
      store_outcome_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_outcome = '{found_value_i, status_i, entry_count_i};
        if (store_outcome_q.size() == 0) begin
          report_failure($sformatf("unexpected result: found %0d status %0d count %0d",
                                   got_outcome.found, got_outcome.status, got_outcome.count));
        end else begin
          want_outcome = store_outcome_q.pop_front();
          if (got_outcome.found !== want_outcome.found ||
              got_outcome.status !== want_outcome.status ||
              got_outcome.count !== want_outcome.count) begin
            report_failure($sformatf(
              "mismatch: expected found %0d status %0d count %0d, got found %0d status %0d count %0d",
              want_outcome.found, want_outcome.status, want_outcome.count,
              got_outcome.found, got_outcome.status, got_outcome.count));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_store_command(op_i, data_value_i, want_outcome);
        store_outcome_q.push_back(want_outcome);
      end
    end
    pending_o <= store_outcome_q.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// testbench top for the ordered store: stimulus, handshake idling and verdict
module tb;

  localparam int unsigned CAPACITY   = 16;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          HOLD_LEN   = 200;
  localparam int          DRAIN_WAIT = 64;
  localparam int          RAND_ITEMS = 1120;
  localparam int          CALM_TAIL  = 100;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic [1:0]                        op_i          = osem_pkg::OP_INSERT;
  logic signed [osem_pkg::DataW-1:0] data_value_i  = '0;
  logic                              out_ready_i   = 1'b0;
  logic                              in_ready_o;
  logic                              out_valid_o;
  logic signed [osem_pkg::DataW-1:0] found_value_o;
  logic [1:0]                        status_o;
  logic [osem_pkg::CountW-1:0]       entry_count_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int hold_count  = 0;
  bit calm        = 1'b0;

  ordered_store_extract_max_unit #(.CAPACITY(CAPACITY)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .data_value_i  (data_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_value_o (found_value_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  osem_result_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .op_i          (op_i),
    .data_value_i  (data_value_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_value_i (found_value_o),
    .status_i      (status_o),
    .entry_count_i (entry_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, plus long hold-offs while the sender keeps offering
  initial begin
    int burst;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_count < 2 && items_sent >= 300 + hold_count * 400) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk_i);
        hold_count++;
      end else if (calm) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        burst = $urandom_range(1, 4);
        out_ready_i <= ($urandom_range(0, 2) != 0);
        repeat (burst) @(posedge clk_i);
      end
    end
  end

  // one transaction, held until accepted
  task automatic send_command(input logic [1:0] op,
                              input logic signed [osem_pkg::DataW-1:0] val);
    in_valid_i   <= 1'b1;
    op_i         <= op;
    data_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // extremes, a small range for ties, or anything
  function automatic logic signed [osem_pkg::DataW-1:0] pick_value();
    int v;
    v = $urandom_range(0, 7);
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return v - 4;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int ins_pct;
    int r;
    logic [1:0] op;

    // reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store errors, negative-only store, ties, full store
    send_command(osem_pkg::OP_PEEK, '0);
    send_command(osem_pkg::OP_DELETE, 32'sh7FFF_FFFF);
    send_command(OP_UNUSED, -1);
    send_command(osem_pkg::OP_INSERT, 32'sh8000_0000);
    send_command(osem_pkg::OP_INSERT, -1);
    send_command(osem_pkg::OP_PEEK, 32'sh1234_5678);
    send_command(osem_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_command(osem_pkg::OP_INSERT, 32'sh7FFF_FFFF);
    send_command(osem_pkg::OP_PEEK, '0);
    send_command(osem_pkg::OP_DELETE, '0);
    send_command(osem_pkg::OP_DELETE, '0);
    for (int i = 0; i < 14; i++) send_command(osem_pkg::OP_INSERT, pick_value());
    send_command(osem_pkg::OP_INSERT, 32'sh5555_5555);
    send_command(OP_UNUSED, 32'shAAAA_AAAA);
    send_command(osem_pkg::OP_PEEK, '0);

    // random: phases that fill, drain or balance the store
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: ins_pct = 70;
          1: ins_pct = 20;
          default: ins_pct = 45;
        endcase
        calm = (n >= RAND_ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_UNUSED;
      else if (r < 4 + ins_pct) op = osem_pkg::OP_INSERT;
      else if (r[0]) op = osem_pkg::OP_DELETE;
      else op = osem_pkg::OP_PEEK;
      send_command(op, pick_value());
    end
    in_valid_i <= 1'b0;

    // drain and verdict
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
